/* rtl/core/bdec_pkg.sv */
// Package for the base64 stream decoder: character classes, the decode
// function and the job word that passes from the front end to the back end.
// No dependencies; all files but the checker use it by scoped names.
`default_nettype none

package bdec_pkg;

    // Sextet values of the two punctuation members of the alphabet.
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    // Characters with a special meaning.
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_PAD = 8'h3D;

    // Depth of the job queue between front and back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // How the front end treats one character.
    typedef enum logic [1:0] {
        CLS_DATA,
        CLS_SKIP,
        CLS_END
    } char_class_t;

    // One unit of work for the back end: up to three bytes, most
    // significant first. A byte count of zero means a single empty
    // end-of-message item.
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  nbytes;
        logic        last_of_msg;
    } job_t;

    // Classify a character.
    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t cls;
        case (c) inside
            ["A":"Z"], ["a":"z"], ["0":"9"], "+", "/": cls = CLS_DATA;
            CHAR_NUL, CHAR_PAD:                        cls = CLS_END;
            default:                                   cls = CLS_SKIP;
        endcase
        return cls;
    endfunction

    // Sextet value of an alphabet character; zero for anything else.
    function automatic logic [5:0] sextet(input logic [7:0] c);
        logic [5:0] s;
        case (c) inside
            ["A":"Z"]: s = 6'(c - 8'h41);
            ["a":"z"]: s = 6'(c - 8'h61 + 8'd26);
            ["0":"9"]: s = 6'(c - 8'h30 + 8'd52);
            "+":       s = SEXTET_PLUS;
            "/":       s = SEXTET_SLASH;
            default:   s = 6'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/bdec_front.sv */
// Front end of the base64 stream decoder: accepts characters, gathers
// sextets and hands complete groups and message ends to the job queue.
// Depends on bdec_pkg.
`default_nettype none

module bdec_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          char_valid,
    output logic               char_ready,
    input  wire logic [7:0]    text_char,
    input  wire logic          queue_full,
    output logic               push,
    output bdec_pkg::job_t     push_job
);

    logic [17:0]           acc_reg, acc_next;
    logic [1:0]            count_reg, count_next;
    logic                  wait_reg, wait_next;
    bdec_pkg::char_class_t cls;
    logic [5:0]            sx;
    logic                  take;

    // A character is taken whenever the queue can hold a job.
    assign char_ready = !queue_full;
    assign take       = char_valid && char_ready;
    assign cls        = bdec_pkg::classify(text_char);
    assign sx         = bdec_pkg::sextet(text_char);

    // Group state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            count_reg <= '0;
            wait_reg  <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            count_reg <= count_next;
            wait_reg  <= wait_next;
        end
    end

    // Classification and job building.
    always_comb
    begin
        acc_next   = acc_reg;
        count_next = count_reg;
        wait_next  = wait_reg;
        push       = 1'b0;
        push_job   = '0;
        if (take)
        begin
            if (wait_reg)
            begin
                // After padding, only a NUL re-arms the decoder.
                if (text_char == bdec_pkg::CHAR_NUL)
                begin
                    wait_next = 1'b0;
                end
            end
            else
            begin
                case (cls)
                    bdec_pkg::CLS_DATA:
                    begin
                        if (count_reg == 2'd3)
                        begin
                            push               = 1'b1;
                            push_job.word      = {acc_reg, sx};
                            push_job.nbytes    = 2'd3;
                            acc_next           = '0;
                            count_next         = '0;
                        end
                        else
                        begin
                            acc_next   = {acc_reg[11:0], sx};
                            count_next = count_reg + 2'd1;
                        end
                    end
                    bdec_pkg::CLS_END:
                    begin
                        // Flush the partial group, missing sextets as zero.
                        push                 = 1'b1;
                        push_job.last_of_msg = 1'b1;
                        case (count_reg)
                            2'd1:
                            begin
                                push_job.word   = {acc_reg[5:0], 18'd0};
                                push_job.nbytes = 2'd0;
                            end
                            2'd2:
                            begin
                                push_job.word   = {acc_reg[11:0], 12'd0};
                                push_job.nbytes = 2'd1;
                            end
                            2'd3:
                            begin
                                push_job.word   = {acc_reg, 6'd0};
                                push_job.nbytes = 2'd2;
                            end
                            default:
                            begin
                                push_job.word   = '0;
                                push_job.nbytes = 2'd0;
                            end
                        endcase
                        acc_next   = '0;
                        count_next = '0;
                        wait_next  = (text_char == bdec_pkg::CHAR_PAD);
                    end
                    default:
                    begin
                        // Characters outside the alphabet are dropped.
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/bdec_queue.sv */
// Job queue of the base64 stream decoder: a small register file FIFO that
// lets the front and back ends stall independently.
// Depends on bdec_pkg.
`default_nettype none

module bdec_queue
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire bdec_pkg::job_t push_job,
    input  wire logic           pop,
    output logic                full,
    output logic                not_empty,
    output bdec_pkg::job_t      head
);

    bdec_pkg::job_t                  mem [bdec_pkg::QUEUE_DEPTH];
    logic [bdec_pkg::QUEUE_AW-1:0]   wptr_reg, rptr_reg;
    logic [bdec_pkg::QUEUE_AW:0]     fill_reg, fill_next;

    assign full      = (fill_reg == (bdec_pkg::QUEUE_AW+1)'(bdec_pkg::QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head      = mem[rptr_reg];

    // Storage: payload only, no reset needed.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= push_job;
        end
    end

    // Fill level.
    always_comb
    begin
        fill_next = fill_reg;
        case ({push, pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    // Pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/bdec_back.sv */
// Back end of the base64 stream decoder: takes jobs from the queue and
// presents their bytes one item per cycle while result_ready is high.
// Depends on bdec_pkg.
`default_nettype none

module bdec_back
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           queue_not_empty,
    input  wire bdec_pkg::job_t head,
    output logic                pop,
    output logic                result_valid,
    input  wire logic           result_ready,
    output logic [7:0]          out_byte,
    output logic                byte_valid,
    output logic                end_of_message
);

    bdec_pkg::job_t job_reg;
    logic [1:0]     idx_reg, idx_next;
    logic           busy_reg, busy_next;
    logic [1:0]     last_idx;
    logic           at_last;
    logic           done;

    // Position of the final item of the current job.
    assign last_idx = (job_reg.nbytes == 2'd0) ? 2'd0 : job_reg.nbytes - 2'd1;
    assign at_last  = (idx_reg == last_idx);
    assign done     = busy_reg && result_ready && at_last;
    assign pop      = queue_not_empty && (!busy_reg || done);

    // Result item selection from the held job.
    always_comb
    begin
        case (idx_reg)
            2'd0:    out_byte = job_reg.word[23:16];
            2'd1:    out_byte = job_reg.word[15:8];
            default: out_byte = job_reg.word[7:0];
        endcase
        if (job_reg.nbytes == 2'd0)
        begin
            out_byte = 8'd0;
        end
    end

    assign result_valid   = busy_reg;
    assign byte_valid     = (job_reg.nbytes != 2'd0);
    assign end_of_message = job_reg.last_of_msg && at_last;

    // Sequencing through the bytes of a job.
    always_comb
    begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (pop)
        begin
            idx_next  = 2'd0;
            busy_next = 1'b1;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg && result_ready)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    // Job payload register.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/base64_stream_decoder.sv */
// Base64 stream decoder: one character accepted per cycle while the queue is
// not full; up to three result items per job, presented one per cycle while
// result_ready is high. A job enters the queue at the accepting edge and loads
// into the back end's job register when the back end pops it. A four-entry job
// queue lets the input run ahead of a stalled output. Reset (rst_n low,
// asynchronous) clears group state, queue pointers and output valid at once.
`default_nettype none

module base64_stream_decoder
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       char_valid,
    output logic            char_ready,
    input  wire logic [7:0] text_char,
    output logic            result_valid,
    input  wire logic       result_ready,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            end_of_message
);

    logic           push;
    bdec_pkg::job_t push_job;
    logic           pop;
    logic           queue_full;
    logic           queue_not_empty;
    bdec_pkg::job_t head;

    // Character intake and sextet gathering.
    bdec_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .text_char  (text_char),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    // Jobs waiting for the output side.
    bdec_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (head)
    );

    // Byte serialisation.
    bdec_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .queue_not_empty (queue_not_empty),
        .head            (head),
        .pop             (pop),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .out_byte        (out_byte),
        .byte_valid      (byte_valid),
        .end_of_message  (end_of_message)
    );

endmodule

`default_nettype wire

/* rtl/core/bdec_checker.sv */
// Port-level checks for the base64 stream decoder, bound to the top level.
// Depends only on the ports of base64_stream_decoder.
`default_nettype none

module bdec_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       char_valid,
    input wire logic       char_ready,
    input wire logic [7:0] text_char,
    input wire logic       result_valid,
    input wire logic       result_ready,
    input wire logic [7:0] out_byte,
    input wire logic       byte_valid,
    input wire logic       end_of_message
);

    // A stalled result transfer holds its item.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(out_byte) && $stable(byte_valid)
            && $stable(end_of_message))
        else $error("result item changed while stalled");

    // An item without a byte only ever closes a message.
    a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !byte_valid |-> end_of_message)
        else $error("empty result item without end of message");

    // An item without a byte carries a zero byte.
    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !byte_valid |-> out_byte == 8'd0)
        else $error("empty result item with non-zero byte");

endmodule

bind base64_stream_decoder bdec_checker u_bdec_checker (.*);

`default_nettype wire
